FILE: sv/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants for the text console writer: operation codes,
// controller command and datapath status bundles, cell format constants.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  localparam int CELL_W = 16;

  localparam logic [7:0] BLANK_CHAR   = 8'd32;
  localparam logic [7:0] NEWLINE_CHAR = 8'd10;
  localparam logic [7:0] ATTR_RESET   = 8'd7;

  typedef enum logic [1:0] {
    OP_PUT    = 2'd0,
    OP_CLEAR  = 2'd1,
    OP_SCROLL = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  typedef struct packed {
    logic load_in;
    logic start_item;
    logic put;
    logic home;
    logic scroll_setup;
    logic rd_index;
    logic rd_src;
    logic capture_rd;
    logic copy_write;
    logic blank_write;
    logic load_out;
  } tcw_cmd_t;

  typedef struct packed {
    op_t  op;
    logic put_ovf;
    logic lines_zero;
    logic lines_ge_rows;
    logic index_ok;
    logic copy_done;
    logic blank_done;
    logic out_busy;
  } tcw_sts_t;

endpackage

FILE: sv/tcw_ram.sv
// ----------------------------------------------------------------------------
// tcw_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: sv/tcw_ctrl.sv
// ----------------------------------------------------------------------------
// tcw_ctrl
// Controller for the text console writer: sequences put, clear, scroll and
// read requests over the datapath and the cell store.
// ----------------------------------------------------------------------------
module tcw_ctrl
  import tcw_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output tcw_cmd_t cmd,
  input  tcw_sts_t sts
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_PUT,
    ST_SCR_SETUP,
    ST_COPY_RD,
    ST_COPY_WR,
    ST_BLANK,
    ST_RD_WAIT,
    ST_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && in_ready_r) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_DECODE;
        end
      end
      ST_DECODE: begin
        cmd.start_item = 1'b1;
        case (sts.op)
          OP_PUT: begin
            state_nxt = ST_PUT;
          end
          OP_CLEAR: begin
            cmd.home  = 1'b1;
            state_nxt = ST_BLANK;
          end
          OP_SCROLL: begin
            if (sts.lines_zero) begin
              state_nxt = ST_FINISH;
            end else if (sts.lines_ge_rows) begin
              cmd.home  = 1'b1;
              state_nxt = ST_BLANK;
            end else begin
              state_nxt = ST_SCR_SETUP;
            end
          end
          OP_READ: begin
            if (sts.index_ok) begin
              cmd.rd_index = 1'b1;
              state_nxt    = ST_RD_WAIT;
            end else begin
              state_nxt = ST_FINISH;
            end
          end
          default: begin
            state_nxt = ST_FINISH;
          end
        endcase
      end
      ST_PUT: begin
        cmd.put   = 1'b1;
        state_nxt = sts.put_ovf ? ST_SCR_SETUP : ST_FINISH;
      end
      ST_SCR_SETUP: begin
        cmd.scroll_setup = 1'b1;
        state_nxt        = ST_COPY_RD;
      end
      ST_COPY_RD: begin
        if (sts.copy_done) begin
          state_nxt = ST_BLANK;
        end else begin
          cmd.rd_src = 1'b1;
          state_nxt  = ST_COPY_WR;
        end
      end
      ST_COPY_WR: begin
        cmd.copy_write = 1'b1;
        state_nxt      = ST_COPY_RD;
      end
      ST_BLANK: begin
        if (sts.blank_done) begin
          state_nxt = ST_FINISH;
        end else begin
          cmd.blank_write = 1'b1;
        end
      end
      ST_RD_WAIT: begin
        cmd.capture_rd = 1'b1;
        state_nxt      = ST_FINISH;
      end
      ST_FINISH: begin
        if (!sts.out_busy) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      in_ready_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      in_ready_r <= (state_nxt == ST_IDLE);
    end
  end

  assign in_ready = in_ready_r;

  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |-> (state_r == ST_IDLE))
    else $error("request accepted outside idle");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> !sts.out_busy)
    else $error("result loaded over a pending result");

  a_copy_order: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.copy_write |-> ($past(state_r) == ST_COPY_RD))
    else $error("copy write without a preceding read");

  a_ready_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> in_ready)
    else $error("not ready after result load");

endmodule

FILE: sv/tcw_datapath.sv
// ----------------------------------------------------------------------------
// tcw_datapath
// Datapath for the text console writer: request and cursor registers, store
// address counters, cell store and result register.
// ----------------------------------------------------------------------------
module tcw_datapath
  import tcw_pkg::*;
#(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  tcw_cmd_t    cmd,
  output tcw_sts_t    sts,
  input  logic [1:0]  in_operation,
  input  logic [7:0]  in_char_code,
  input  logic [7:0]  in_line_count,
  input  logic [10:0] in_cell_index,
  input  logic        cfg_valid,
  input  logic [7:0]  cfg_default_attribute,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [6:0]  out_cursor_column,
  output logic [4:0]  out_cursor_row,
  output logic [10:0] out_cursor_offset,
  output logic [7:0]  out_cell_char,
  output logic [7:0]  out_cell_attribute,
  output logic        out_scrolled
);

  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int AW = $clog2(CELL_COUNT);
  localparam int NW = $clog2(CELL_COUNT + 1);
  localparam int CW = $clog2(COLUMNS);
  localparam int RW = $clog2(ROWS);

  op_t          op_r;
  logic [7:0]   ch_r;
  logic [7:0]   lines_r;
  logic [10:0]  index_r;
  logic [7:0]   attr_r;
  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [NW-1:0] idx_r;
  logic [NW-1:0] src_r;
  logic [7:0]   rd_char_r;
  logic [7:0]   rd_attr_r;
  logic         scrolled_r;

  logic         out_valid_r;
  logic [6:0]   out_col_r;
  logic [4:0]   out_row_r;
  logic [10:0]  out_off_r;
  logic [7:0]   out_char_r;
  logic [7:0]   out_attr_r;
  logic         out_scr_r;

  logic [NW-1:0]     cur_pos;
  logic [CW:0]       col_inc;
  logic [RW:0]       row_inc;
  logic [RW:0]       row_wide;
  logic              is_newline;
  logic              put_ovf;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [CELL_W-1:0] ram_wdata;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [CELL_W-1:0] ram_rdata;

  assign cur_pos    = NW'(32'(row_r) * COLUMNS + 32'(col_r));
  assign col_inc    = {1'b0, col_r} + 1'b1;
  assign row_inc    = {1'b0, row_r} + 1'b1;
  assign is_newline = (ch_r == NEWLINE_CHAR);

  always_comb begin
    if (is_newline) begin
      col_nxt  = '0;
      row_wide = row_inc;
    end else if (col_inc == (CW + 1)'(COLUMNS)) begin
      col_nxt  = '0;
      row_wide = row_inc;
    end else begin
      col_nxt  = col_inc[CW-1:0];
      row_wide = {1'b0, row_r};
    end
    put_ovf = (row_wide == (RW + 1)'(ROWS));
    row_nxt = put_ovf ? RW'(ROWS - 1) : row_wide[RW-1:0];
  end

  always_comb begin
    ram_we    = (cmd.put && !is_newline) || cmd.copy_write || cmd.blank_write;
    ram_waddr = cmd.put ? cur_pos[AW-1:0] : idx_r[AW-1:0];
    if (cmd.put) begin
      ram_wdata = {attr_r, ch_r};
    end else if (cmd.copy_write) begin
      ram_wdata = ram_rdata;
    end else begin
      ram_wdata = {attr_r, BLANK_CHAR};
    end
    ram_re    = cmd.rd_index || cmd.rd_src;
    ram_raddr = cmd.rd_index ? AW'(index_r) : src_r[AW-1:0];
  end

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELL_COUNT)
  ) u_cells (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r    <= op_t'(in_operation);
      ch_r    <= in_char_code;
      index_r <= in_cell_index;
    end
    if (cmd.start_item) begin
      rd_char_r  <= '0;
      rd_attr_r  <= '0;
      scrolled_r <= 1'b0;
    end
    if (cmd.capture_rd) begin
      rd_char_r <= ram_rdata[7:0];
      rd_attr_r <= ram_rdata[15:8];
    end
    if (cmd.put && put_ovf) begin
      scrolled_r <= 1'b1;
    end
    if (cmd.load_out) begin
      out_col_r  <= 7'(col_r);
      out_row_r  <= 5'(row_r);
      out_off_r  <= 11'(cur_pos);
      out_char_r <= rd_char_r;
      out_attr_r <= rd_attr_r;
      out_scr_r  <= scrolled_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r      <= ATTR_RESET;
      col_r       <= '0;
      row_r       <= '0;
      idx_r       <= '0;
      src_r       <= '0;
      lines_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        attr_r <= cfg_default_attribute;
      end
      if (cmd.load_in) begin
        lines_r <= in_line_count;
      end
      if (cmd.put) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
        if (put_ovf) begin
          lines_r <= 8'd1;
        end
      end
      if (cmd.home) begin
        col_r <= '0;
        row_r <= '0;
        idx_r <= '0;
      end
      if (cmd.scroll_setup) begin
        idx_r <= '0;
        src_r <= NW'(32'(lines_r[RW-1:0]) * COLUMNS);
      end
      if (cmd.copy_write) begin
        idx_r <= idx_r + 1'b1;
        src_r <= src_r + 1'b1;
      end
      if (cmd.blank_write) begin
        idx_r <= idx_r + 1'b1;
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_comb begin
    sts.op            = op_r;
    sts.put_ovf       = put_ovf;
    sts.lines_zero    = (lines_r == 8'd0);
    sts.lines_ge_rows = (32'(lines_r) >= ROWS);
    sts.index_ok      = (32'(index_r) < CELL_COUNT);
    sts.copy_done     = (src_r == NW'(CELL_COUNT));
    sts.blank_done    = (idx_r == NW'(CELL_COUNT));
    sts.out_busy      = out_valid_r && !out_ready;
  end

  assign out_valid          = out_valid_r;
  assign out_cursor_column  = out_col_r;
  assign out_cursor_row     = out_row_r;
  assign out_cursor_offset  = out_off_r;
  assign out_cell_char      = out_char_r;
  assign out_cell_attribute = out_attr_r;
  assign out_scrolled       = out_scr_r;

  a_cursor_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(col_r) < COLUMNS) && (32'(row_r) < ROWS))
    else $error("cursor outside the screen");

  a_idx_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    32'(idx_r) <= CELL_COUNT)
    else $error("store counter past the end");

  a_out_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_valid)
    else $error("result not presented after load");

endmodule

FILE: sv/text_console_writer_top.sv
// ----------------------------------------------------------------------------
// text_console_writer_top
// Text-mode console engine over a COLUMNS x ROWS store of character and
// attribute cells.
//
// Requests enter on in_* (valid/ready): put character (code 10 is newline),
// clear screen, scroll up by in_line_count, read cell at in_cell_index. Each
// request yields one result on out_*: cursor position and offset after the
// request, the read cell (zero for other requests), and a scroll flag.
// cfg_* writes the attribute byte used for every written and blank cell; it
// is always ready; the user must write it only while no request is in flight,
// as the block itself does not enforce this.
// A partial scroll by N, or a put that scrolls, walks the store: it reads
// and then writes each moved cell, (ROWS-N)*COLUMNS of them, then blanks
// N*COLUMNS cells. A new request can be taken in the cycle after the
// previous result is loaded into the output register.
// Reset homes the cursor, sets the attribute to 7 and empties the output;
// the store is not cleared, so software clears the screen first. When the
// receiver stalls, the result waits in the output register and the next
// request is worked up to its result, then holds until the slot frees.
// ----------------------------------------------------------------------------
module text_console_writer_top
  import tcw_pkg::*;
#(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_operation,
  input  logic [7:0]  in_char_code,
  input  logic [7:0]  in_line_count,
  input  logic [10:0] in_cell_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [6:0]  out_cursor_column,
  output logic [4:0]  out_cursor_row,
  output logic [10:0] out_cursor_offset,
  output logic [7:0]  out_cell_char,
  output logic [7:0]  out_cell_attribute,
  output logic        out_scrolled,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_default_attribute
);

  tcw_cmd_t cmd;
  tcw_sts_t sts;

  assign cfg_ready = 1'b1;

  tcw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  tcw_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .sts                   (sts),
    .in_operation          (in_operation),
    .in_char_code          (in_char_code),
    .in_line_count         (in_line_count),
    .in_cell_index         (in_cell_index),
    .cfg_valid             (cfg_valid),
    .cfg_default_attribute (cfg_default_attribute),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_cursor_column     (out_cursor_column),
    .out_cursor_row        (out_cursor_row),
    .out_cursor_offset     (out_cursor_offset),
    .out_cell_char         (out_cell_char),
    .out_cell_attribute    (out_cell_attribute),
    .out_scrolled          (out_scrolled)
  );

endmodule

FILE: sim/tb_text_console_writer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_text_console_writer_top
// Self-checking bench for the text console writer. A shadow screen, cursor
// and attribute register track each accepted request and predict the cursor
// report. Directed requests cover field extremes, newline, the edge reads and
// the scroll corner cases. Random phases then mix text lines, newline runs,
// reads, scrolls and clears under several attribute settings, with random
// idling on both sides outside the calm phase and long receiver hold-offs.
// ----------------------------------------------------------------------------
module tb_text_console_writer_top;
  import tcw_pkg::*;

  localparam int COLS         = COLUMNS_DEF;
  localparam int ROWS         = ROWS_DEF;
  localparam int CELLS        = COLS * ROWS;
  localparam int CYCLE_LIMIT  = 12_000_000;
  localparam int HOLD_CYCLES  = 500;
  localparam int HOLD_SPACING = 240;
  localparam int DRAIN_CYCLES = 20;
  localparam int MAX_REPORTS  = 10;
  localparam int PHASE_ITEMS  = 130;

  typedef struct packed {
    op_t        op;
    logic [7:0] char_code;
    logic [7:0] line_count;
    logic [10:0] cell_index;
  } console_req_t;

  typedef struct packed {
    logic [6:0]  col;
    logic [4:0]  row;
    logic [10:0] offset;
    logic [7:0]  cell_char;
    logic [7:0]  cell_attr;
    logic        scrolled;
  } cursor_report_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_operation = OP_PUT;
  logic [7:0]  in_char_code = 8'd0;
  logic [7:0]  in_line_count = 8'd0;
  logic [10:0] in_cell_index = 11'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [6:0]  out_cursor_column;
  logic [4:0]  out_cursor_row;
  logic [10:0] out_cursor_offset;
  logic [7:0]  out_cell_char;
  logic [7:0]  out_cell_attribute;
  logic        out_scrolled;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_default_attribute = 8'd0;

  console_req_t   request_q[$];
  cursor_report_t cursor_reports_q[$];
  console_req_t   drive_req;
  cursor_report_t predicted;
  cursor_report_t got;
  cursor_report_t want;

  logic [15:0] shadow_cells [CELLS];
  int          shadow_col = 0;
  int          shadow_row = 0;
  logic [7:0]  shadow_attr = ATTR_RESET;

  int   queued_cnt = 0;
  int   accepted_cnt = 0;
  int   results_seen = 0;
  int   fail_cnt = 0;
  int   cycle_cnt = 0;
  int   hold_left = 0;
  int   next_hold = 100;
  logic calm = 1'b0;

  text_console_writer_top uut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_operation          (in_operation),
    .in_char_code          (in_char_code),
    .in_line_count         (in_line_count),
    .in_cell_index         (in_cell_index),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_cursor_column     (out_cursor_column),
    .out_cursor_row        (out_cursor_row),
    .out_cursor_offset     (out_cursor_offset),
    .out_cell_char         (out_cell_char),
    .out_cell_attribute    (out_cell_attribute),
    .out_scrolled          (out_scrolled),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_default_attribute (cfg_default_attribute)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic shadow_clear();
    int i;
    for (i = 0; i < CELLS; i++) shadow_cells[i] = {shadow_attr, BLANK_CHAR};
    shadow_col = 0;
    shadow_row = 0;
  endtask

  task automatic shadow_scroll(input int n);
    int i;
    int keep;
    if (n == 0) return;
    if (n >= ROWS) begin
      shadow_clear();
      return;
    end
    keep = (ROWS - n) * COLS;
    for (i = 0; i < keep; i++) shadow_cells[i] = shadow_cells[i + n * COLS];
    for (i = keep; i < CELLS; i++) shadow_cells[i] = {shadow_attr, BLANK_CHAR};
  endtask

  task automatic apply_console_request(input console_req_t r, output cursor_report_t e);
    int pos;
    e = '0;
    case (r.op)
      OP_PUT: begin
        if (r.char_code == NEWLINE_CHAR) begin
          shadow_col = 0;
          shadow_row++;
        end else begin
          pos = shadow_row * COLS + shadow_col;
          if (pos < CELLS) shadow_cells[pos] = {shadow_attr, r.char_code};
          shadow_col++;
        end
        if (shadow_col >= COLS) begin
          shadow_col = 0;
          shadow_row++;
        end
        if (shadow_row >= ROWS) begin
          shadow_scroll(1);
          shadow_row = ROWS - 1;
          e.scrolled = 1'b1;
        end
      end
      OP_CLEAR: shadow_clear();
      OP_SCROLL: shadow_scroll(int'(r.line_count));
      default: begin
        if (int'(r.cell_index) < CELLS) begin
          e.cell_char = shadow_cells[r.cell_index][7:0];
          e.cell_attr = shadow_cells[r.cell_index][15:8];
        end
      end
    endcase
    pos = shadow_row * COLS + shadow_col;
    e.col = shadow_col[6:0];
    e.row = shadow_row[4:0];
    e.offset = pos[10:0];
  endtask

  task automatic add_req(input op_t op, input logic [7:0] ch, input logic [7:0] lines,
                         input logic [10:0] idx);
    console_req_t r;
    r.op = op;
    r.char_code = ch;
    r.line_count = lines;
    r.cell_index = idx;
    request_q.push_back(r);
    queued_cnt++;
  endtask

  task automatic drain();
    while (results_seen < queued_cnt) @(posedge clk);
  endtask

  task automatic write_attribute(input logic [7:0] v);
    @(posedge clk);
    cfg_default_attribute <= v;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    shadow_attr = v;
    cfg_valid <= 1'b0;
  endtask

  task automatic queue_directed();
    add_req(OP_CLEAR,  8'($urandom), 8'($urandom), 11'($urandom));
    add_req(OP_READ,   8'($urandom), 8'($urandom), 11'd0);
    add_req(OP_PUT,    8'd0,         8'($urandom), 11'($urandom));
    add_req(OP_PUT,    8'd255,       8'($urandom), 11'($urandom));
    add_req(OP_PUT,    8'h41,        8'($urandom), 11'($urandom));
    add_req(OP_PUT,    NEWLINE_CHAR, 8'($urandom), 11'($urandom));
    add_req(OP_PUT,    8'h42,        8'($urandom), 11'($urandom));
    add_req(OP_READ,   8'($urandom), 8'($urandom), 11'd0);
    add_req(OP_READ,   8'($urandom), 8'($urandom), 11'd1);
    add_req(OP_READ,   8'($urandom), 8'($urandom), 11'd2);
    add_req(OP_READ,   8'($urandom), 8'($urandom), 11'd80);
    add_req(OP_READ,   8'($urandom), 8'($urandom), 11'd1999);
    add_req(OP_READ,   8'($urandom), 8'($urandom), 11'd2000);
    add_req(OP_READ,   8'($urandom), 8'($urandom), 11'd2047);
    add_req(OP_SCROLL, 8'($urandom), 8'd0,         11'($urandom));
    add_req(OP_SCROLL, 8'($urandom), 8'd1,         11'($urandom));
    add_req(OP_READ,   8'($urandom), 8'($urandom), 11'd0);
    add_req(OP_SCROLL, 8'($urandom), 8'd24,        11'($urandom));
    add_req(OP_READ,   8'($urandom), 8'($urandom), 11'd1920);
    add_req(OP_PUT,    8'h43,        8'($urandom), 11'($urandom));
    add_req(OP_SCROLL, 8'($urandom), 8'd25,        11'($urandom));
    add_req(OP_PUT,    8'h44,        8'($urandom), 11'($urandom));
    add_req(OP_SCROLL, 8'($urandom), 8'd255,       11'($urandom));
    add_req(OP_READ,   8'($urandom), 8'($urandom), 11'd0);
    add_req(OP_READ,   8'($urandom), 8'($urandom), 11'd1024);
  endtask

  task automatic queue_random_phase(input int n);
    int start;
    int kind;
    int len;
    int k;
    logic [7:0]  ch;
    logic [7:0]  lines;
    logic [10:0] idx;
    start = queued_cnt;
    while (queued_cnt - start < n) begin
      kind = int'($urandom_range(99));
      if (kind < 40) begin
        // text line: mostly short, now and then long enough to wrap
        if ($urandom_range(19) == 0) len = int'($urandom_range(170, 70));
        else len = int'($urandom_range(20));
        for (k = 0; k < len; k++) begin
          if ($urandom_range(7) == 0) ch = 8'($urandom_range(255));
          else ch = 8'($urandom_range(126, 32));
          add_req(OP_PUT, ch, 8'($urandom), 11'($urandom));
        end
        if ($urandom_range(4) != 0) add_req(OP_PUT, NEWLINE_CHAR, 8'($urandom), 11'($urandom));
      end else if (kind < 70) begin
        len = int'($urandom_range(4, 1));
        for (k = 0; k < len; k++) begin
          if ($urandom_range(9) == 0) idx = 11'($urandom_range(2047, 2000));
          else idx = 11'($urandom_range(CELLS - 1));
          add_req(OP_READ, 8'($urandom), 8'($urandom), idx);
        end
      end else if (kind < 80) begin
        k = int'($urandom_range(99));
        if (k < 25) lines = 8'd0;
        else if (k < 80) lines = 8'($urandom_range(ROWS - 1, 1));
        else lines = 8'($urandom_range(255));
        add_req(OP_SCROLL, 8'($urandom), lines, 11'($urandom));
      end else if (kind < 82) begin
        add_req(OP_CLEAR, 8'($urandom), 8'($urandom), 11'($urandom));
      end else if (kind < 87) begin
        // newline run: push the cursor down, at times past the bottom row
        len = int'($urandom_range(26, 1));
        for (k = 0; k < len; k++) add_req(OP_PUT, NEWLINE_CHAR, 8'($urandom), 11'($urandom));
      end else begin
        add_req(op_t'(2'($urandom_range(3))), 8'($urandom), 8'($urandom), 11'($urandom));
      end
    end
  endtask

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // hold off the receiver now and then so the block backs up
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (accepted_cnt >= next_hold) begin
      hold_left <= HOLD_CYCLES;
      next_hold <= next_hold + HOLD_SPACING;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        apply_console_request(drive_req, predicted);
        cursor_reports_q.push_back(predicted);
        accepted_cnt <= accepted_cnt + 1;
      end
      if (!in_valid || in_ready) begin
        if (request_q.size() != 0 && (calm || $urandom_range(99) >= 17)) begin
          drive_req = request_q.pop_front();
          in_valid <= 1'b1;
          in_operation <= drive_req.op;
          in_char_code <= drive_req.char_code;
          in_line_count <= drive_req.line_count;
          in_cell_index <= drive_req.cell_index;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        got = {out_cursor_column, out_cursor_row, out_cursor_offset,
               out_cell_char, out_cell_attribute, out_scrolled};
        if (cursor_reports_q.size() == 0) begin
          if (fail_cnt < MAX_REPORTS)
            $display("unrequested report: col %0d row %0d off %0d char %0d attr %0d scr %0d",
                     got.col, got.row, got.offset, got.cell_char, got.cell_attr, got.scrolled);
          fail_cnt++;
        end else begin
          want = cursor_reports_q.pop_front();
          if (got !== want) begin
            if (fail_cnt < MAX_REPORTS)
              $display({"mismatch (expected/actual): col %0d/%0d row %0d/%0d off %0d/%0d",
                        " char %0d/%0d attr %0d/%0d scr %0d/%0d"},
                       want.col, got.col, want.row, got.row, want.offset, got.offset,
                       want.cell_char, got.cell_char, want.cell_attr, got.cell_attr,
                       want.scrolled, got.scrolled);
            fail_cnt++;
          end
        end
      end
      out_ready <= (hold_left == 0) && (calm || $urandom_range(99) >= 17);
    end
  end

  initial begin
    logic [7:0] phase_attr [5];
    int ph;
    phase_attr[0] = 8'hFF;
    phase_attr[1] = 8'h00;
    phase_attr[2] = 8'($urandom_range(255));
    phase_attr[3] = 8'($urandom_range(255));
    phase_attr[4] = 8'h80;
    for (ph = 0; ph < CELLS; ph++) shadow_cells[ph] = 16'd0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    queue_directed();
    drain();
    for (ph = 0; ph < 5; ph++) begin
      write_attribute(phase_attr[ph]);
      calm = (ph == 2);
      queue_random_phase(PHASE_ITEMS);
      drain();
    end
    calm = 1'b0;
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_cnt == 0 && cursor_reports_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
